@@ rtl/wfd_pkg.sv @@
// wfd_pkg: shared types, codes and constants for the weight frame deframer
// used by wfd_parse, wfd_out_queue and weight_frame_deframer
`default_nettype none

package wfd_pkg;

  // header layout
  localparam logic [3:0] HDR_LEN   = 4'd12;
  localparam logic [3:0] MAGIC_LEN = 4'd4;
  localparam logic [3:0] SMPL_END  = 4'd8;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_MAGIC   = 2'd0,
    PH_COUNTS  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ELEMENT = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BADMAGIC = 2'd2,
    ST_LENGTH   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] sample_count;
    logic [31:0] element_count;
    logic [31:0] element_index;
    logic [63:0] value_bits;
    logic [1:0]  frame_status;
    logic        last_result;
  } res_item_t;

  // up to two results pushed per parsed byte
  typedef struct packed {
    logic [1:0] cnt;
    res_item_t  r0;
    res_item_t  r1;
  } push_t;

  localparam res_item_t RES_ZERO = '0;

  // expected magic byte by position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h57;
      2'd1:    b = 8'h46;
      2'd2:    b = 8'h4C;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/weight_frame_deframer.sv @@
// weight_frame_deframer: a byte passes the input register and the result queue before
// its first result reaches out_*. throughput is one byte per cycle while the queue has room;
// a byte's two results (header or element, and end of frame) share the single queue read port.
// reset (rst_n low, synchronous) clears the parser to the magic phase and empties the queue.
// top level, depends on wfd_pkg, wfd_parse and wfd_out_queue
`default_nettype none

module weight_frame_deframer
  import wfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output res_item_t      out_data
);

  push_t push;
  logic  room;

  // byte parser with input register
  wfd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // result queue toward the consumer
  wfd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/wfd_out_queue.sv @@
// wfd_out_queue: four-entry result queue, up to two pushes and one pop per cycle
// depends on wfd_pkg for the result and push types
`default_nettype none

module wfd_out_queue
  import wfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire push_t     push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output res_item_t      out_data
);

  res_item_t        mem [QDEPTH];
  logic [QPW-1:0]   wp_r, wp_nxt;
  logic [QPW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic [QPW-1:0]   wp_plus1;

  // handshake toward the consumer
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= QCW'(QDEPTH - 2));
  assign wp_plus1  = wp_r + QPW'(1);

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r + QPW'(push.cnt);
    rp_nxt  = pop ? rp_r + QPW'(1) : rp_r;
    cnt_nxt = cnt_r + QCW'(push.cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_plus1] <= push.r1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("push into result queue without room");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result transaction changed");

endmodule

`default_nettype wire

@@ rtl/wfd_parse.sv @@
// wfd_parse: input register and frame parser, yields up to two results per byte
// depends on wfd_pkg for types, codes and the magic table
`default_nettype none

module wfd_parse
  import wfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      room,
  output push_t          push
);

  logic        in_vld_r, in_vld_nxt;
  in_item_t    in_r;
  logic        accept;
  logic        consume;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bpos_r, bpos_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic [31:0] smpl_r, smpl_nxt;
  logic [31:0] elems_r, elems_nxt;
  logic [31:0] done_r, done_nxt;
  logic [63:0] word_r, word_nxt;
  logic        overrun_r, overrun_nxt;

  res_item_t   first_res;
  logic        first_vld;
  res_item_t   end_res;
  logic [1:0]  status;

  // input register, refilled as it drains
  assign consume  = in_vld_r && room;
  assign in_stall = in_vld_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // frame parsing for one byte
  always_comb begin
    phase_nxt    = phase_r;
    bpos_nxt     = bpos_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    magic_ok_nxt = magic_ok_r;
    smpl_nxt     = smpl_r;
    elems_nxt    = elems_r;
    done_nxt     = done_r;
    word_nxt     = word_r;
    overrun_nxt  = overrun_r;
    first_res    = RES_ZERO;
    first_vld    = 1'b0;
    end_res      = RES_ZERO;
    status       = ST_OK;
    push         = '0;

    if (phase_r != PH_PAYLOAD) begin
      if (hdr_cnt_r < MAGIC_LEN) begin
        if (in_r.data_byte != magic_byte(hdr_cnt_r[1:0])) begin
          magic_ok_nxt = 1'b0;
        end
      end else if (hdr_cnt_r < SMPL_END) begin
        smpl_nxt = {smpl_r[23:0], in_r.data_byte};
      end else begin
        elems_nxt = {elems_r[23:0], in_r.data_byte};
      end
      hdr_cnt_nxt = hdr_cnt_r + 4'd1;
      phase_nxt   = (hdr_cnt_nxt >= MAGIC_LEN) ? PH_COUNTS : PH_MAGIC;
      if (hdr_cnt_nxt >= HDR_LEN) begin
        phase_nxt               = PH_PAYLOAD;
        first_vld               = 1'b1;
        first_res.result_kind   = KIND_HEADER;
        first_res.sample_count  = smpl_nxt;
        first_res.element_count = elems_nxt;
      end
    end else if (done_r >= elems_r) begin
      overrun_nxt = 1'b1;
    end else begin
      word_nxt = {word_r[55:0], in_r.data_byte};
      bpos_nxt = bpos_r + 3'd1;
      if (bpos_nxt == 3'd0) begin
        first_vld               = 1'b1;
        first_res.result_kind   = KIND_ELEMENT;
        first_res.element_index = done_r;
        first_res.value_bits    = word_nxt;
        done_nxt                = done_r + 32'd1;
        word_nxt                = '0;
      end
    end

    // end-of-frame status, in precedence order
    if (hdr_cnt_nxt < HDR_LEN) begin
      status = ST_SHORT;
    end else if (!magic_ok_nxt) begin
      status = ST_BADMAGIC;
    end else if (overrun_nxt || bpos_nxt != 3'd0 || done_nxt != elems_nxt) begin
      status = ST_LENGTH;
    end
    end_res.result_kind  = KIND_END;
    end_res.frame_status = status;
    end_res.last_result  = 1'b1;

    // assemble the transactions for the queue
    if (consume) begin
      if (first_vld) begin
        push.r0  = first_res;
        push.r1  = end_res;
        push.cnt = in_r.last_byte ? 2'd2 : 2'd1;
      end else if (in_r.last_byte) begin
        push.r0  = end_res;
        push.cnt = 2'd1;
      end
    end

    // frame done: back to reset values
    if (in_r.last_byte) begin
      phase_nxt    = PH_MAGIC;
      bpos_nxt     = '0;
      hdr_cnt_nxt  = '0;
      magic_ok_nxt = 1'b1;
      smpl_nxt     = '0;
      elems_nxt    = '0;
      done_nxt     = '0;
      word_nxt     = '0;
      overrun_nxt  = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      bpos_r     <= '0;
      hdr_cnt_r  <= '0;
      magic_ok_r <= 1'b1;
      smpl_r     <= '0;
      elems_r    <= '0;
      done_r     <= '0;
      word_r     <= '0;
      overrun_r  <= 1'b0;
    end else if (consume) begin
      phase_r    <= phase_nxt;
      bpos_r     <= bpos_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      magic_ok_r <= magic_ok_nxt;
      smpl_r     <= smpl_nxt;
      elems_r    <= elems_nxt;
      done_r     <= done_nxt;
      word_r     <= word_nxt;
      overrun_r  <= overrun_nxt;
    end
  end

  a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_r.last_byte) |=> (hdr_cnt_r == 4'd0 && phase_r == PH_MAGIC))
    else $error("parser state not cleared after frame end");

  a_payload_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (hdr_cnt_r == HDR_LEN))
    else $error("payload phase without full header");

  a_word_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (bpos_r != 3'd0 || overrun_r) |-> (phase_r == PH_PAYLOAD))
    else $error("word gathering outside payload phase");

endmodule

`default_nettype wire

@@ tb/tb_weight_frame_deframer.sv @@
// testbench for weight_frame_deframer: byte-stream frames against a built-in deframing model
// depends on wfd_pkg (item types, kind and status codes, header constants) and the top level
`default_nettype none

module tb_weight_frame_deframer;
  import wfd_pkg::*;

  // one row of the directed table; the end status is typed in where it is obvious
  typedef struct {
    in_item_t  item;
    bit        typed;
    status_t   end_status;
  } dir_row_t;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h57, 8'h46, 8'h4C, 8'h31};
  localparam int ITEM_TARGET = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  res_item_t out_data;

  weight_frame_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // deframer model state
  phase_t      dfm_phase;
  logic [2:0]  dfm_word_pos;
  logic [3:0]  dfm_hdr_seen;
  bit          dfm_magic_ok;
  logic [31:0] dfm_samples;
  logic [31:0] dfm_elems;
  logic [31:0] dfm_done;
  logic [63:0] dfm_word;
  bit          dfm_overrun;

  res_item_t   pending_results [$];
  dir_row_t    row_marks [$];
  dir_row_t    directed_rows [$];
  logic [7:0]  frame_bytes [$];

  int          idle_pct;
  int          stall_pct;
  int          errors;
  int          bytes_sent;
  int          frames_sent;
  int          results_checked;
  int          end_hits [4];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("[weight_frame_deframer] ERROR");
    $finish;
  end

  task automatic clear_model();
    dfm_phase    = PH_MAGIC;
    dfm_word_pos = '0;
    dfm_hdr_seen = '0;
    dfm_magic_ok = 1'b1;
    dfm_samples  = '0;
    dfm_elems    = '0;
    dfm_done     = '0;
    dfm_word     = '0;
    dfm_overrun  = 1'b0;
  endtask

  // advance the deframer model by one byte and queue the results it yields
  task automatic deframe_byte(input in_item_t it);
    res_item_t r;
    status_t   st;
    if (dfm_phase != PH_PAYLOAD) begin
      if (dfm_hdr_seen < MAGIC_LEN) begin
        if (it.data_byte != MAGIC_BYTES[dfm_hdr_seen[1:0]]) dfm_magic_ok = 1'b0;
      end else if (dfm_hdr_seen < SMPL_END) begin
        dfm_samples = {dfm_samples[23:0], it.data_byte};
      end else begin
        dfm_elems = {dfm_elems[23:0], it.data_byte};
      end
      dfm_hdr_seen = dfm_hdr_seen + 4'd1;
      dfm_phase = (dfm_hdr_seen >= MAGIC_LEN) ? PH_COUNTS : PH_MAGIC;
      if (dfm_hdr_seen >= HDR_LEN) begin
        dfm_phase = PH_PAYLOAD;
        r = RES_ZERO;
        r.result_kind   = KIND_HEADER;
        r.sample_count  = dfm_samples;
        r.element_count = dfm_elems;
        pending_results.insert(pending_results.size(), r);
      end
    end else if (dfm_done >= dfm_elems) begin
      dfm_overrun = 1'b1;
    end else begin
      dfm_word     = {dfm_word[55:0], it.data_byte};
      dfm_word_pos = dfm_word_pos + 3'd1;
      if (dfm_word_pos == 3'd0) begin
        r = RES_ZERO;
        r.result_kind   = KIND_ELEMENT;
        r.element_index = dfm_done;
        r.value_bits    = dfm_word;
        pending_results.insert(pending_results.size(), r);
        dfm_done = dfm_done + 32'd1;
        dfm_word = '0;
      end
    end
    // end of frame: status by precedence, then back to the reset state
    if (it.last_byte) begin
      if (dfm_hdr_seen < HDR_LEN)
        st = ST_SHORT;
      else if (!dfm_magic_ok)
        st = ST_BADMAGIC;
      else if (dfm_overrun || dfm_word_pos != 3'd0 || dfm_done != dfm_elems)
        st = ST_LENGTH;
      else
        st = ST_OK;
      r = RES_ZERO;
      r.result_kind  = KIND_END;
      r.frame_status = st;
      r.last_result  = 1'b1;
      pending_results.insert(pending_results.size(), r);
      end_hits[st] = end_hits[st] + 1;
      clear_model();
    end
  endtask

  // compare one delivered result with the oldest expectation
  task automatic match_result(input res_item_t got);
    res_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, none pending: got %h", $time, got);
      errors++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (got.result_kind !== want.result_kind) begin
        $display("%0t: result_kind expected %0d got %0d", $time, want.result_kind,
                 got.result_kind);
        errors++;
      end
      if (got.sample_count !== want.sample_count) begin
        $display("%0t: sample_count expected %h got %h", $time, want.sample_count,
                 got.sample_count);
        errors++;
      end
      if (got.element_count !== want.element_count) begin
        $display("%0t: element_count expected %h got %h", $time, want.element_count,
                 got.element_count);
        errors++;
      end
      if (got.element_index !== want.element_index) begin
        $display("%0t: element_index expected %0d got %0d", $time, want.element_index,
                 got.element_index);
        errors++;
      end
      if (got.value_bits !== want.value_bits) begin
        $display("%0t: value_bits expected %h got %h", $time, want.value_bits,
                 got.value_bits);
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $display("%0t: frame_status expected %0d got %0d", $time, want.frame_status,
                 got.frame_status);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result expected %0d got %0d", $time, want.last_result,
                 got.last_result);
        errors++;
      end
    end
  endtask

  // monitor: model the accepted byte first, then check the accepted result
  always @(posedge clk) begin
    dir_row_t mark;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mark = row_marks.pop_front();
        deframe_byte(in_data);
        if (mark.typed) begin
          if (pending_results.size() == 0 ||
              pending_results[$].result_kind != KIND_END ||
              pending_results[$].frame_status != mark.end_status) begin
            $display("%0t: table end status %0d disagrees with model", $time,
                     mark.end_status);
            errors++;
          end
        end
      end
      if (out_valid && !out_stall) match_result(out_data);
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // drive one byte, with random idle cycles ahead of it, and wait for its transaction
  task automatic send_byte(input in_item_t it, input bit typed, input status_t st);
    dir_row_t mark;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    mark.item       = it;
    mark.typed      = typed;
    mark.end_status = st;
    row_marks.insert(row_marks.size(), mark);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (it.last_byte) frames_sent++;
  endtask

  task automatic add_row(input logic [7:0] b, input bit last, input bit typed,
                         input status_t st);
    dir_row_t row;
    row.item.data_byte = b;
    row.item.last_byte = last;
    row.typed          = typed;
    row.end_status     = st;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), w[i*8 +: 8]);
  endtask

  // build one random frame: mostly well formed, some broken in each way
  task automatic build_frame();
    int          pick;
    int          n_elem;
    int          cut;
    logic [31:0] count_field;
    frame_bytes.delete();
    pick   = $urandom_range(99);
    n_elem = $urandom_range(0, 4);
    count_field = n_elem;
    // long advertised payload that the frame then cuts short
    if (pick >= 80 && pick < 90) begin
      if ($urandom_range(3) == 0) count_field = $urandom;
      else count_field = n_elem + $urandom_range(1, 2);
    end
    for (int i = 0; i < 4; i++) frame_bytes.insert(frame_bytes.size(), MAGIC_BYTES[i]);
    if (pick >= 60 && pick < 70) begin
      cut = $urandom_range(0, 3);
      frame_bytes[cut] = frame_bytes[cut] ^ 8'($urandom_range(1, 255));
    end
    push_word($urandom);
    push_word(count_field);
    for (int i = 0; i < 8 * n_elem; i++)
      frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
    // trailing bytes past the advertised length
    if (pick >= 70 && pick < 80) begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++)
        frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
    end
    // partial trailing word
    if (pick >= 80 && pick < 90 && $urandom_range(1) == 1) begin
      cut = $urandom_range(1, 7);
      for (int i = 0; i < cut; i++)
        frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
    end
    // header cut short, sometimes pure noise
    if (pick >= 90) begin
      cut = $urandom_range(1, 11);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      if ($urandom_range(1) == 1)
        foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom_range(255));
    end
  endtask

  // stimulus
  initial begin
    in_item_t it;
    int       quarter;
    int       drain;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    errors    = 0;
    bytes_sent      = 0;
    frames_sent     = 0;
    results_checked = 0;
    foreach (end_hits[i]) end_hits[i] = 0;
    clear_model();

    // header ends on the last byte, count fields at their extremes
    add_row(8'h57, 1'b0, 1'b0, ST_OK);
    add_row(8'h46, 1'b0, 1'b0, ST_OK);
    add_row(8'h4C, 1'b0, 1'b0, ST_OK);
    add_row(8'h31, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b1, 1'b1, ST_OK);
    // one-byte frame
    add_row(8'h57, 1'b1, 1'b1, ST_SHORT);
    // wrong last magic byte, huge element count, nothing after the header
    add_row(8'h57, 1'b0, 1'b0, ST_OK);
    add_row(8'h46, 1'b0, 1'b0, ST_OK);
    add_row(8'h4C, 1'b0, 1'b0, ST_OK);
    add_row(8'h30, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b1, 1'b1, ST_BADMAGIC);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_rows[i])
      send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].end_status);

    // random frames in four idling phases
    while (bytes_sent < ITEM_TARGET + directed_rows.size()) begin
      quarter = (bytes_sent - directed_rows.size()) / (ITEM_TARGET / 4);
      case (quarter)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      build_frame();
      foreach (frame_bytes[i]) begin
        it.data_byte = frame_bytes[i];
        it.last_byte = (i == frame_bytes.size() - 1);
        send_byte(it, 1'b0, ST_OK);
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching the output for anything unexpected
    while (pending_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end

    $display("covered %0d frames, %0d bytes, %0d results checked", frames_sent,
             bytes_sent, results_checked);
    $display("end status mix ok/short/magic/length: %0d/%0d/%0d/%0d", end_hits[ST_OK],
             end_hits[ST_SHORT], end_hits[ST_BADMAGIC], end_hits[ST_LENGTH]);
    if (errors == 0) begin
      $display("[weight_frame_deframer] OK");
    end else begin
      $display("[weight_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
